// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler heading block
// Concurrent checks on the rising edge of clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every edge out of reset.
`define QTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// An antecedent that implies a consequent in the same cycle.
`define QTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// An antecedent that implies a consequent in the next cycle.
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QTE_ASSERT(lbl, clk, rst_n, prop)
`define QTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/qte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_TAB_LEN     = 24;

  // Angles are held as radians * 2^30.
  localparam int ZW            = 34;
  localparam int FRAC_BITS     = 30;
  localparam int PRESCALE_LOG  = 48;
  localparam int PRESCALE_NUM  = 6;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic [29:0]          DEG_PER_RAD_Q24 = 30'd961263669;

  // Configuration register indexes.
  localparam logic REG_DEGREE_MODE    = 1'b0;
  localparam logic REG_HEADING_OFFSET = 1'b1;

  // Axis flags of one atan2 operand pair.
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic x_neg;
    logic y_pos;
  } spec_t;

  // Arctangent of 2^-idx in radians * 2^30.
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 34'sh03243F6A8;
      1:  v = 34'sh01DAC6705;
      2:  v = 34'sh00FADBAFC;
      3:  v = 34'sh007F56EA6;
      4:  v = 34'sh003FEAB76;
      5:  v = 34'sh001FFD55B;
      6:  v = 34'sh000FFFAAA;
      7:  v = 34'sh0007FFF55;
      8:  v = 34'sh0003FFFEA;
      9:  v = 34'sh0001FFFFD;
      10: v = 34'sh0000FFFFF;
      11: v = 34'sh00007FFFF;
      12: v = 34'sh00003FFFF;
      13: v = 34'sh00001FFFF;
      14: v = 34'sh00000FFFF;
      15: v = 34'sh000007FFF;
      16: v = 34'sh000003FFF;
      17: v = 34'sh000001FFF;
      18: v = 34'sh000000FFF;
      19: v = 34'sh0000007FF;
      20: v = 34'sh0000003FF;
      21: v = 34'sh0000001FF;
      22: v = 34'sh0000000FF;
      23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/qte_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module qte_div_cell import qte_pkg::*; #(
  parameter int NW = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NW-1:0]        n_i,
  input  logic [NW-1:0]        d_i,
  input  logic [FRAC_BITS-1:0] q_i,
  output logic [NW-1:0]        n_o,
  output logic [NW-1:0]        d_o,
  output logic [FRAC_BITS-1:0] q_o
);

  logic [NW:0] n2;
  logic [NW:0] diff;
  logic        take;

  // Shift the remainder up and subtract the divisor when it fits.
  always_comb begin
    n2   = {n_i, 1'b0};
    diff = n2 - {1'b0, d_i};
    take = (n2 >= {1'b0, d_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_o <= take ? diff[NW-1:0] : n2[NW-1:0];
      d_o <= d_i;
      q_o <= {q_i[FRAC_BITS-2:0], take};
    end
  end

endmodule

// ===== sv/qte_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit-by-digit integer square root step for a fixed test bit.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
  parameter int BITPOS = 60
) (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_i,
  input  logic [60:0] r_i,
  output logic [60:0] v_o,
  output logic [60:0] r_o
);

  localparam logic [61:0] BIT = 62'd1 << BITPOS;

  logic [61:0] trial;
  logic [61:0] rem;
  logic [61:0] rsum;
  logic        take;

  // Try to subtract the running root plus the test bit.
  always_comb begin
    trial = {1'b0, r_i} + BIT;
    take  = ({1'b0, v_i} >= trial);
    rem   = {1'b0, v_i} - trial;
    rsum  = {2'd0, r_i[60:1]} + BIT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_o <= take ? rem[60:0] : v_i;
      r_o <= take ? rsum[60:0] : {1'b0, r_i[60:1]};
    end
  end

endmodule

// ===== sv/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation toward the positive x axis.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
  parameter int DW  = 53,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 hold_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 hold_o,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ANG = atan_q30(IDX);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
  end

  // A held word already carries its final angle and passes unchanged.
  always_ff @(posedge clk) begin
    if (en) begin
      hold_o <= hold_i;
      if (hold_i) begin
        x_o <= x_i;
        y_o <= y_i;
        z_o <= z_i;
      end else if (y_i > 0) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ANG;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ANG;
      end
    end
  end

endmodule

// ===== sv/qte_atan2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2: staged prescale, quadrant fold, then a row of CORDIC cells.
// ----------------------------------------------------------------------------
module qte_atan2 import qte_pkg::*; #(
  parameter int DW    = 53,
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  output logic signed [ZW-1:0] z_o
);

  localparam int NS = (STEPS < ATAN_TAB_LEN) ? STEPS : ATAN_TAB_LEN;

  logic signed [DW-1:0] px [0:PRESCALE_NUM];
  logic signed [DW-1:0] py [0:PRESCALE_NUM];
  logic        [DW-1:0] pm [0:PRESCALE_NUM];
  spec_t                ps [0:PRESCALE_NUM];

  logic                 ch [0:NS];
  logic signed [DW-1:0] cx [0:NS];
  logic signed [DW-1:0] cy [0:NS];
  logic signed [ZW-1:0] cz [0:NS];

  logic        [DW-1:0] ax;
  logic        [DW-1:0] ay;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic                 dbl;

  // Magnitude bound and axis flags of the incoming pair.
  always_comb begin
    ax = x_i[DW-1] ? DW'(-x_i) : DW'(x_i);
    ay = y_i[DW-1] ? DW'(-y_i) : DW'(y_i);
  end

  assign px[0] = x_i;
  assign py[0] = y_i;
  assign pm[0] = ax | ay;
  assign ps[0] = '{y_zero: (y_i == 0), x_zero: (x_i == 0),
                   x_neg: x_i[DW-1], y_pos: (y_i > 0)};

  // Binary search of the doubling count, largest shift first.
  for (genvar k = 0; k < PRESCALE_NUM; k++) begin : g_pre
    localparam int SH  = 1 << (PRESCALE_NUM - 1 - k);
    localparam int LIM = PRESCALE_LOG - SH;
    always_ff @(posedge clk) begin
      if (en) begin
        ps[k+1] <= ps[k];
        if ((pm[k] >> LIM) == '0) begin
          px[k+1] <= px[k] <<< SH;
          py[k+1] <= py[k] <<< SH;
          pm[k+1] <= pm[k] << SH;
        end else begin
          px[k+1] <= px[k];
          py[k+1] <= py[k];
          pm[k+1] <= pm[k];
        end
      end
    end
  end

  // Final doubling, then settle the axis cases or fold the left half plane onto the right.
  always_comb begin
    dbl = ((pm[PRESCALE_NUM] >> PRESCALE_LOG) == '0);
    xs  = dbl ? (px[PRESCALE_NUM] <<< 1) : px[PRESCALE_NUM];
    ys  = dbl ? (py[PRESCALE_NUM] <<< 1) : py[PRESCALE_NUM];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch[0] <= 1'b0;
      cx[0] <= xs;
      cy[0] <= ys;
      cz[0] <= '0;
      if (ps[PRESCALE_NUM].y_zero) begin
        ch[0] <= 1'b1;
        cz[0] <= ps[PRESCALE_NUM].x_neg ? PI_Q30 : '0;
      end else if (ps[PRESCALE_NUM].x_zero) begin
        ch[0] <= 1'b1;
        cz[0] <= ps[PRESCALE_NUM].y_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
      end else if (xs < 0) begin
        if (ys >= 0) begin
          cx[0] <= ys;
          cy[0] <= -xs;
          cz[0] <= HALF_PI_Q30;
        end else begin
          cx[0] <= -ys;
          cy[0] <= xs;
          cz[0] <= -HALF_PI_Q30;
        end
      end
    end
  end

  // Row of micro-rotation cells.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    qte_cordic_cell #(.DW(DW), .IDX(i)) u_cell (
      .clk    (clk),
      .en     (en),
      .hold_i (ch[i]),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .z_i    (cz[i]),
      .hold_o (ch[i+1]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .z_o    (cz[i+1])
    );
  end

  assign z_o = cz[NS];

endmodule

// ===== sv/quaternion_to_euler_heading.sv =====
`timescale 1ns / 1ps
// The pipeline depth from input word to result word is set by the 30-cell
// divider, the 31-cell square root and the CORDIC row that the pitch path
// runs after them. Throughput: one word per cycle; the whole pipeline stalls
// only while a result word waits at the output. Synchronous active-low reset
// clears the valid bits and sets degree mode with a zero heading offset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_heading
// Converts a quaternion to yaw, pitch, roll and a whole-degree compass heading.
// ----------------------------------------------------------------------------
module quaternion_to_euler_heading import qte_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_j,
  input  logic signed [SAMPLE_WIDTH-1:0] in_quat_k,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_yaw_angle,
  output logic signed [15:0]             out_pitch_angle,
  output logic signed [15:0]             out_roll_angle,
  output logic        [8:0]              out_heading_degrees,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic        [8:0]              cfg_data
);

  localparam int PW  = 2 * SAMPLE_WIDTH;
  localparam int NW  = 2 * SAMPLE_WIDTH + 3;
  localparam int DW  = (2 * SAMPLE_WIDTH + 4 > 53) ? 2 * SAMPLE_WIDTH + 4 : 53;
  localparam int NS  = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int DIV_N  = FRAC_BITS;
  localparam int SQRT_N = 31;
  localparam int ALIGN  = DIV_N + 1 + SQRT_N;
  localparam int LAT    = 2 + ALIGN + PRESCALE_NUM + 1 + NS + 3;

  typedef struct packed {
    logic neg;
    logic sat;
  } pflag_t;

  logic       en;
  logic [LAT-1:0] vld_r;
  logic       degree_mode_r;
  logic [8:0] heading_offset_r;

  // Stage one: squares and cross products.
  logic signed [PW-1:0] sw_r, sx_r, sy_r, sz_r, xy_r, zw_r, yz_r, xw_r, xz_r, yw_r;
  // Stage two: atan2 operands and the pitch fraction operands.
  logic signed [DW-1:0] yaw_y_r, yaw_x_r, roll_y_r, roll_x_r;
  logic signed [NW-1:0] pnum, norm;
  logic        [NW-1:0] mag;

  logic [NW-1:0]        dn [0:DIV_N];
  logic [NW-1:0]        dd [0:DIV_N];
  logic [FRAC_BITS-1:0] dq [0:DIV_N];
  pflag_t               dflag_r [0:DIV_N];

  logic [30:0] s_val;
  logic [60:0] sv [0:SQRT_N];
  logic [60:0] sr [0:SQRT_N];
  logic [31:0] ps_r [0:SQRT_N];

  logic signed [ZW-1:0] yaw_z, roll_z, pitch_z;
  logic signed [ZW-1:0] yawd_r  [0:ALIGN-1];
  logic signed [ZW-1:0] rolld_r [0:ALIGN-1];
  logic signed [DW-1:0] pit_y, pit_x;

  logic signed [ZW-1:0] ang [0:2];
  logic signed [47:0]   ph_r  [0:2];
  logic        [46:0]   pl_r  [0:2];
  logic signed [15:0]   rad_r [0:2];
  logic signed [15:0]   rad2_r [0:2];
  logic signed [17:0]   deg_r [0:2];

  logic signed [17:0] ydeg_adj;
  logic [12:0]        hsum;
  logic [8:0]         hmod;

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_mode_r    <= 1'b1;
      heading_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE_MODE:    degree_mode_r    <= cfg_data[0];
        REG_HEADING_OFFSET: heading_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products of the quaternion components.
  always_ff @(posedge clk) begin
    if (en) begin
      sw_r <= in_quat_real * in_quat_real;
      sx_r <= in_quat_i * in_quat_i;
      sy_r <= in_quat_j * in_quat_j;
      sz_r <= in_quat_k * in_quat_k;
      xy_r <= in_quat_i * in_quat_j;
      zw_r <= in_quat_k * in_quat_real;
      yz_r <= in_quat_j * in_quat_k;
      xw_r <= in_quat_i * in_quat_real;
      xz_r <= in_quat_i * in_quat_k;
      yw_r <= in_quat_j * in_quat_real;
    end
  end

  // Sums for the two atan2 pairs, the pitch numerator and the norm.
  always_comb begin
    pnum = (NW'(yw_r) - NW'(xz_r)) <<< 1;
    norm = NW'(sx_r) + NW'(sy_r) + NW'(sz_r) + NW'(sw_r);
    mag  = pnum[NW-1] ? NW'(-pnum) : NW'(pnum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_y_r  <= DW'((NW'(xy_r) + NW'(zw_r)) <<< 1);
      yaw_x_r  <= DW'(NW'(sx_r) - NW'(sy_r) - NW'(sz_r) + NW'(sw_r));
      roll_y_r <= DW'((NW'(yz_r) + NW'(xw_r)) <<< 1);
      roll_x_r <= DW'(NW'(sz_r) + NW'(sw_r) - NW'(sx_r) - NW'(sy_r));
      // An all-zero quaternion divides zero by one, which yields a zero pitch.
      if (norm == 0) begin
        dn[0]      <= '0;
        dd[0]      <= NW'(1);
        dflag_r[0] <= '{neg: 1'b0, sat: 1'b0};
      end else begin
        dn[0]      <= (mag >= NW'(norm)) ? '0 : mag;
        dd[0]      <= NW'(norm);
        dflag_r[0] <= '{neg: pnum[NW-1], sat: (mag >= NW'(norm))};
      end
      dq[0] <= '0;
    end
  end

  // Yaw and roll run through their CORDIC rows right away.
  qte_atan2 #(.DW(DW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk (clk), .en (en), .x_i (yaw_x_r), .y_i (yaw_y_r), .z_o (yaw_z)
  );

  qte_atan2 #(.DW(DW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk (clk), .en (en), .x_i (roll_x_r), .y_i (roll_y_r), .z_o (roll_z)
  );

  // Sine of pitch as a 30-bit fraction, one quotient bit per cell.
  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    qte_div_cell #(.NW(NW)) u_cell (
      .clk (clk), .en (en),
      .n_i (dn[i]), .d_i (dd[i]), .q_i (dq[i]),
      .n_o (dn[i+1]), .d_o (dd[i+1]), .q_o (dq[i+1])
    );
  end

  for (genvar i = 1; i <= DIV_N; i++) begin : g_dflag
    always_ff @(posedge clk) begin
      if (en) dflag_r[i] <= dflag_r[i-1];
    end
  end

  // Square the sine and take the cosine radicand.
  assign s_val = dflag_r[DIV_N].sat ? 31'h40000000 : {1'b0, dq[DIV_N]};

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0]   <= 61'h1000000000000000 - 61'(s_val * s_val);
      sr[0]   <= '0;
      ps_r[0] <= {dflag_r[DIV_N].neg, s_val};
    end
  end

  // Cosine of pitch, one root bit per cell.
  for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
    qte_sqrt_cell #(.BITPOS(60 - 2 * j)) u_cell (
      .clk (clk), .en (en),
      .v_i (sv[j]), .r_i (sr[j]),
      .v_o (sv[j+1]), .r_o (sr[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) ps_r[j+1] <= ps_r[j];
    end
  end

  assign pit_y = ps_r[SQRT_N][31] ? -DW'(ps_r[SQRT_N][30:0]) : DW'(ps_r[SQRT_N][30:0]);
  assign pit_x = DW'(sr[SQRT_N]);

  qte_atan2 #(.DW(DW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk (clk), .en (en), .x_i (pit_x), .y_i (pit_y), .z_o (pitch_z)
  );

  // Hold yaw and roll until the pitch of the same word is done.
  always_ff @(posedge clk) begin
    if (en) begin
      yawd_r[0]  <= yaw_z;
      rolld_r[0] <= roll_z;
    end
  end

  for (genvar i = 1; i < ALIGN; i++) begin : g_align
    always_ff @(posedge clk) begin
      if (en) begin
        yawd_r[i]  <= yawd_r[i-1];
        rolld_r[i] <= rolld_r[i-1];
      end
    end
  end

  assign ang[0] = yawd_r[ALIGN-1];
  assign ang[1] = pitch_z;
  assign ang[2] = rolld_r[ALIGN-1];

  // Unit conversion: split degree product, then sum and round.
  for (genvar a = 0; a < 3; a++) begin : g_conv
    logic signed [ZW:0]  rsum;
    logic signed [65:0]  dsum;
    assign rsum = (ZW+1)'(ang[a]) + (ZW+1)'(35'sd131072);
    assign dsum = (66'(ph_r[a]) <<< 17) + 66'(pl_r[a]) + (66'sd1 <<< 47);
    always_ff @(posedge clk) begin
      if (en) begin
        ph_r[a]   <= $signed(ang[a][ZW-1:17]) * $signed({1'b0, DEG_PER_RAD_Q24});
        pl_r[a]   <= ang[a][16:0] * DEG_PER_RAD_Q24;
        rad_r[a]  <= rsum[33:18];
        deg_r[a]  <= dsum[65:48];
        rad2_r[a] <= rad_r[a];
      end
    end
  end

  // Compass heading from the degree yaw, offset and wrapped.
  always_comb begin
    ydeg_adj = deg_r[0][17] ? deg_r[0] + 18'sd23040 : deg_r[0];
    hsum     = 13'(ydeg_adj[17:6]) + 13'(heading_offset_r);
    if (hsum >= 13'd720) begin
      hmod = 9'(hsum - 13'd720);
    end else if (hsum >= 13'd360) begin
      hmod = 9'(hsum - 13'd360);
    end else begin
      hmod = hsum[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_yaw_angle       <= degree_mode_r ? deg_r[0][15:0] : rad2_r[0];
      out_pitch_angle     <= degree_mode_r ? deg_r[1][15:0] : rad2_r[1];
      out_roll_angle      <= degree_mode_r ? deg_r[2][15:0] : rad2_r[2];
      out_heading_degrees <= hmod;
    end
  end

  // Checks on the output stage and the stall logic.
`include "assert_macros.svh"
  `QTE_ASSERT_IMP(a_stall_only_full, clk, rst_n, !in_ready, out_valid)
  `QTE_ASSERT_IMP(a_heading_range, clk, rst_n, out_valid, out_heading_degrees < 9'd360)
  `QTE_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_heading_degrees) && $stable(out_pitch_angle))

endmodule
